>>> rtl/core/fixed_point_q24_7_alu_defines.svh
// Assertion macros used by the checker file.
`ifndef FIXED_POINT_Q24_7_ALU_DEFINES_SVH
`define FIXED_POINT_Q24_7_ALU_DEFINES_SVH
// Checked property with reset masking.
`define FPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
// Checked property that also holds across reset.
`define FPA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

>>> rtl/core/fpa_pkg.sv
// Shared types and constants for the Q24.7 arithmetic unit.
package fpa_pkg;
  localparam int FRAC_BITS = 7;
  localparam int WORD      = 32;
  localparam int QW        = WORD + FRAC_BITS;
  localparam int EXP_BIAS  = 127;
  localparam int MANT_BITS = 23;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_INT = 3'd4,
    MODE_FLT = 3'd5
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } request_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        divide_by_zero;
  } result_t;

  // First stage: decoded operands and early results
  typedef struct packed {
    mode_t              mode;
    logic [WORD-1:0]    sum;
    logic [WORD-1:0]    diff;
    logic [WORD-1:0]    to_int;
    logic signed [63:0] prod;
    logic               neg_a;
    logic [WORD-1:0]    mag;
    logic [4:0]         lead;
    logic               q_neg;
    logic               dz;
    logic [QW-1:0]      dvd;
    logic [WORD-1:0]    dvs;
  } front_t;

  // Side data riding along with the divider
  typedef struct packed {
    mode_t           mode;
    logic [WORD-1:0] plain;
    logic            q_neg;
    logic            dz;
  } side_t;
endpackage

>>> rtl/core/fixed_point_q24_7_alu.sv
// Top level of the Q24.7 fixed-point arithmetic unit.
//
//   channel  | handshake                     | payload
//   request  | request_valid / request_ready | request (mode, operand_a, operand_b)
//   result   | result_valid / result_ready   | result (result_bits, divide_by_zero)
//
// Every mode takes the same path from request to result: one front
// stage, 39 divider stages (one quotient bit each), one output register.
// One request is taken each cycle unless a held result stalls the pipe; the
// divider depth sets the latency. Synchronous reset clears all valid bits and
// holds request_ready low; data registers are not reset.
// A stalled result freezes the whole pipeline, nothing is dropped or repeated.
module fixed_point_q24_7_alu import fpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     request_valid,
  output logic     request_ready,
  input  request_t request,
  output logic     result_valid,
  input  logic     result_ready,
  output result_t  result
);
  logic          en;
  logic          v1;
  logic [QW-1:0] vd;
  front_t        front;
  side_t         side;
  side_t         side_q [QW];
  logic [QW-1:0] quot;
  logic [WORD-1:0] qw;
  result_t       res_next;

  assign en            = !result_valid || result_ready;
  assign request_ready = en && !rst;

  fpa_front u_front (.clk(clk), .en(en), .request(request), .front(front));
  fpa_fin   u_fin   (.front(front), .side(side));
  fpa_div   u_div   (.clk(clk), .en(en), .dvd(front.dvd), .dvs(front.dvs), .quot(quot));

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      vd           <= '0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1           <= request_valid;
      vd           <= {vd[QW-2:0], v1};
      result_valid <= vd[QW-1];
    end
  end

  // side data delay matching the divider
  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side;
      for (int i = 1; i < QW; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // final select with quotient sign fix
  always_comb begin
    qw = quot[WORD-1:0];
    res_next.divide_by_zero = 1'b0;
    res_next.result_bits    = side_q[QW-1].plain;
    if (side_q[QW-1].mode == MODE_DIV) begin
      res_next.divide_by_zero = side_q[QW-1].dz;
      if (side_q[QW-1].dz) begin
        res_next.result_bits = '0;
      end else if (side_q[QW-1].q_neg) begin
        res_next.result_bits = WORD'(0) - qw;
      end else begin
        res_next.result_bits = qw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_next;
    end
  end
endmodule

>>> rtl/core/fpa_front.sv
// Front stage: add, subtract, multiply, integer shift, magnitudes, leading-one search and divider operands.
module fpa_front import fpa_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  request_t request,
  output front_t   front
);
  logic [WORD-1:0] mag_a;
  logic [WORD-1:0] mag_b;
  logic [4:0]      lead;
  logic signed [WORD+FRAC_BITS-1:0] sh;

  // magnitudes, leading one of |a| and the integer shift of a
  always_comb begin
    mag_a = request.operand_a[WORD-1] ? (WORD'(0) - WORD'(request.operand_a))
                                      : WORD'(request.operand_a);
    mag_b = request.operand_b[WORD-1] ? (WORD'(0) - WORD'(request.operand_b))
                                      : WORD'(request.operand_b);
    lead = '0;
    for (int i = 0; i < WORD; i++) begin
      if (mag_a[i]) lead = 5'(i);
    end
    sh = (WORD+FRAC_BITS)'(request.operand_a) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front.mode   <= request.mode;
      front.sum    <= WORD'(request.operand_a) + WORD'(request.operand_b);
      front.diff   <= WORD'(request.operand_a) - WORD'(request.operand_b);
      front.to_int <= sh[WORD-1:0];
      front.prod   <= 64'(request.operand_a) * 64'(request.operand_b);
      front.neg_a  <= request.operand_a[WORD-1];
      front.mag    <= mag_a;
      front.lead   <= lead;
      front.q_neg  <= request.operand_a[WORD-1] ^ request.operand_b[WORD-1];
      front.dz     <= (request.operand_b == '0);
      front.dvd    <= {mag_a, FRAC_BITS'(0)};
      front.dvs    <= mag_b;
    end
  end
endmodule

>>> rtl/core/fpa_fin.sv
// Second stage logic: product scaling, float packing and result select.
module fpa_fin import fpa_pkg::*; (
  input  front_t front,
  output side_t  side
);
  logic [WORD-1:0] mant;
  logic [7:0]      expn;
  logic [WORD-1:0] flt;

  // IEEE single pack, mantissa truncated
  always_comb begin
    if (front.lead > 5'(MANT_BITS)) begin
      mant = front.mag >> (front.lead - 5'(MANT_BITS));
    end else begin
      mant = front.mag << (5'(MANT_BITS) - front.lead);
    end
    expn = 8'(EXP_BIAS - FRAC_BITS) + 8'(front.lead);
    if (front.mag == '0) begin
      flt = '0;
    end else begin
      flt = {front.neg_a, expn, mant[MANT_BITS-1:0]};
    end
  end

  // per-mode select of the non-divide results
  always_comb begin
    side.mode  = front.mode;
    side.q_neg = front.q_neg;
    side.dz    = front.dz;
    case (front.mode)
      MODE_ADD: side.plain = front.sum;
      MODE_SUB: side.plain = front.diff;
      MODE_MUL: side.plain = front.prod[FRAC_BITS+WORD-1:FRAC_BITS];
      MODE_INT: side.plain = front.to_int;
      MODE_FLT: side.plain = flt;
      default:  side.plain = '0;
    endcase
  end
endmodule

>>> rtl/core/fpa_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module fpa_div import fpa_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [QW-1:0]   dvd,
  input  logic [WORD-1:0] dvs,
  output logic [QW-1:0]   quot
);
  logic [WORD-1:0] rem_q [QW];
  logic [QW-1:0]   dq_q  [QW];
  logic [WORD-1:0] dvs_q [QW];
  logic [WORD-1:0] rem_d [QW];
  logic [QW-1:0]   dq_d  [QW];
  logic [WORD-1:0] dvs_s [QW];

  // one compare-subtract per stage
  always_comb begin
    for (int i = 0; i < QW; i++) begin
      logic [WORD-1:0] r_in;
      logic [QW-1:0]   q_in;
      logic [WORD:0]   t;
      r_in = (i == 0) ? '0 : rem_q[(i == 0) ? 0 : i-1];
      q_in = (i == 0) ? dvd : dq_q[(i == 0) ? 0 : i-1];
      dvs_s[i] = (i == 0) ? dvs : dvs_q[(i == 0) ? 0 : i-1];
      t = {r_in, q_in[QW-1]};
      if (t >= {1'b0, dvs_s[i]}) begin
        rem_d[i] = WORD'(t - {1'b0, dvs_s[i]});
        dq_d[i]  = {q_in[QW-2:0], 1'b1};
      end else begin
        rem_d[i] = t[WORD-1:0];
        dq_d[i]  = {q_in[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        rem_q[i] <= rem_d[i];
        dq_q[i]  <= dq_d[i];
        dvs_q[i] <= dvs_s[i];
      end
    end
  end

  assign quot = dq_q[QW-1];
endmodule

>>> rtl/core/fpa_checker.sv
// Port-level checker for the Q24.7 arithmetic unit, bound to the top level.
`include "fixed_point_q24_7_alu_defines.svh"
module fpa_checker import fpa_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     request_ready,
  input logic     result_valid,
  input logic     result_ready,
  input result_t  result
);
  // a held result keeps its payload
  `FPA_ASSERT(a_hold, result_valid && !result_ready |=> result_valid && $stable(result))
  // divide-by-zero always carries a zero result
  `FPA_ASSERT(a_dz_zero, result_valid && result.divide_by_zero |-> result.result_bits == '0)
  // empty output means the pipe can take a request
  `FPA_ASSERT(a_ready, !result_valid |-> request_ready)
  // nothing comes out right after reset
  `FPA_ASSERT_RST(a_rst, rst |=> !result_valid)
endmodule

bind fixed_point_q24_7_alu fpa_checker u_fpa_checker (
  .clk(clk), .rst(rst), .request_ready(request_ready),
  .result_valid(result_valid), .result_ready(result_ready),
  .result(result)
);
